>>> sv/brr_pkg.sv
// Package for the bilinear RGBA resampler: widths, codes, state and shared types.
package brr_pkg;

  // Default largest side of the source store in pixels.
  localparam int MAX_SIDE_DEF = 256;

  // Fixed field widths.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 8;
  localparam int PIX_W     = 32;
  localparam int CH_N      = 4;
  localparam int CH_W      = 8;
  localparam int FRAC_W    = 8;
  localparam int NBR_N     = 4;
  localparam int NBR_W     = $clog2(NBR_N);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_DST_W = 2'd2,
    CFG_DST_H = 2'd3
  } cfg_idx_t;

  // Input word operation codes.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_DIV,
    ST_CLAMP,
    ST_FETCH,
    ST_BLEND,
    ST_MIX,
    ST_DONE
  } brr_state_t;

  // The four neighbours, in the order p00, p01, p10, p11.
  typedef logic [NBR_N-1:0][PIX_W-1:0] quad_t;

  // Stage enables for the blending unit.
  typedef struct packed {
    logic mix_horz;
    logic mix_vert;
  } blend_ctl_t;

endpackage

>>> sv/brr_ifs.sv
// Handshake interfaces for the input, result and configuration channels.
interface brr_in_if import brr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [PIX_W-1:0]   pixel_value;

  modport source (output valid, output opcode, output pixel_x, output pixel_y,
                  output pixel_value, input ready);
  modport sink   (input valid, input opcode, input pixel_x, input pixel_y,
                  input pixel_value, output ready);
endinterface

interface brr_out_if import brr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] sampled_value;

  modport source (output valid, output sampled_value, input ready);
  modport sink   (input valid, input sampled_value, output ready);
endinterface

interface brr_cfg_if import brr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/brr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module brr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/brr_div.sv
// Restoring divider, one quotient bit per cycle.
module brr_div #(
  parameter int DVD_W = 27,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One shift-and-subtract step.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], ge};
    cnt_nxt = cnt_r - CNT_W'(1);
    busy_nxt = busy_r && (cnt_r != CNT_W'(1));
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> sv/brr_blend.sv
// Two-stage bilinear blend of four RGBA neighbours, one lane per channel.
module brr_blend import brr_pkg::*; (
  input  logic              clk,
  input  blend_ctl_t        ctl,
  input  quad_t             quad,
  input  logic [FRAC_W-1:0] wx,
  input  logic [FRAC_W-1:0] wy,
  output logic [PIX_W-1:0]  result
);

  localparam int WGT_W = FRAC_W + 1;
  localparam int TOP_W = CH_W + FRAC_W;
  localparam int MUL_W = TOP_W + 1;
  localparam int ACC_W = TOP_W + FRAC_W + 1;

  logic [WGT_W-1:0]            inv_wx, inv_wy;
  logic [CH_N-1:0][TOP_W-1:0]  top_r, bot_r;
  logic [CH_N-1:0][TOP_W-1:0]  top_nxt, bot_nxt;
  logic [CH_N-1:0][CH_W-1:0]   ch_nxt;
  logic [PIX_W-1:0]            res_r;
  logic [MUL_W-1:0]            t_sum, b_sum;
  logic [ACC_W-1:0]            v_sum;

  assign inv_wx = WGT_W'(1 << FRAC_W) - WGT_W'(wx);
  assign inv_wy = WGT_W'(1 << FRAC_W) - WGT_W'(wy);

  // Horizontal blend of the upper and lower pairs.
  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      t_sum = MUL_W'(quad[0][c*CH_W +: CH_W]) * MUL_W'(inv_wx)
            + MUL_W'(quad[1][c*CH_W +: CH_W]) * MUL_W'(wx);
      b_sum = MUL_W'(quad[2][c*CH_W +: CH_W]) * MUL_W'(inv_wx)
            + MUL_W'(quad[3][c*CH_W +: CH_W]) * MUL_W'(wx);
      top_nxt[c] = t_sum[TOP_W-1:0];
      bot_nxt[c] = b_sum[TOP_W-1:0];
    end
  end

  // Vertical blend, truncated to the channel width.
  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      v_sum = ACC_W'(top_r[c]) * ACC_W'(inv_wy) + ACC_W'(bot_r[c]) * ACC_W'(wy);
      ch_nxt[c] = v_sum[2*FRAC_W +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mix_horz) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
    end
    if (ctl.mix_vert) begin
      res_r <= ch_nxt;
    end
  end

  assign result = res_r;

endmodule

>>> sv/bilinear_rgba_resize_top.sv
// Top level of the bilinear RGBA resampler with half-pixel centres.
//
//   Channel  Direction  Word
//   in_ch    sink       opcode, pixel_x, pixel_y, pixel_value
//   out_ch   source     sampled_value
//   cfg_ch   sink       index, data (source/target width and height)
//
// A write word is taken without holding the input off. A read word, once taken, holds
// the input off while the numerators are formed, the two coordinate divisions run side
// by side, one quotient bit a cycle, the neighbour indices are clamped, the four
// neighbours are read from the single frame RAM read port, the two blend stages run
// and the output register is loaded. The result appears in the cycle the input is
// ready again.
// rst_n is synchronous; it restores all four size registers to one. Frame
// contents are not cleared. A finished result waits in the output register while
// the next word is taken; a read word stalls in its last step until that register frees.
module bilinear_rgba_resize_top import brr_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  brr_in_if.sink   in_ch,
  brr_out_if.source out_ch,
  brr_cfg_if.sink  cfg_ch
);

  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SZ_W   = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SZ_W > CFG_W) ? SZ_W : CFG_W;
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PRD_W  = COORD_W + 1 + SZ_W;
  localparam int NUM_W  = PRD_W + 1;
  localparam int DVD_W  = NUM_W + FRAC_W;
  localparam int DEN_W  = SZ_W + 1;
  localparam int FCNT_W = $clog2(NBR_N + 1);
  localparam logic [ADDR_W-1:0] SIDE_A = ADDR_W'(MAX_SIDE);

  // Effective size: zero acts as one, anything above the store acts as its side.
  function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (v == '0) begin
      eff_size = SZ_W'(1);
    end else if (ve > CMP_W'(MAX_SIDE)) begin
      eff_size = SZ_W'(MAX_SIDE);
    end else begin
      eff_size = SZ_W'(ve);
    end
  endfunction

  brr_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [SZ_W-1:0]   esrc [2];
  logic [SZ_W-1:0]   edst [2];

  logic [COORD_W-1:0] coord_r [2];
  logic [PRD_W-1:0]   prod_r [2];
  logic [PRD_W-1:0]   prod_nxt [2];
  logic               neg_r [2];
  logic               neg_nxt [2];
  logic [DVD_W-1:0]   dvd [2];
  logic [DEN_W-1:0]   dvs [2];
  logic [DVD_W-1:0]   quo [2];
  logic [1:0]         div_busy;
  logic [SIDE_W-1:0]  lo_r [2];
  logic [SIDE_W-1:0]  hi_r [2];
  logic [SIDE_W-1:0]  lo_nxt [2];
  logic [SIDE_W-1:0]  hi_nxt [2];
  logic [FRAC_W-1:0]  w_r [2];

  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [NBR_W-1:0]  fidx;
  quad_t             quad_r;

  logic              in_acc, wr_en, rd_en, div_start, out_load;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_data_r;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [SIDE_W-1:0] ax, ay;
  logic [PIX_W-1:0]  rdata;
  logic [PIX_W-1:0]  blend_res;
  blend_ctl_t        blend_ctl;

  // Configuration registers; the port is always ready.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= CFG_W'(1);
      src_h_r <= CFG_W'(1);
      dst_w_r <= CFG_W'(1);
      dst_h_r <= CFG_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_SRC_W: src_w_r <= cfg_ch.data;
        CFG_SRC_H: src_h_r <= cfg_ch.data;
        CFG_DST_W: dst_w_r <= cfg_ch.data;
        CFG_DST_H: dst_h_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign esrc[0] = eff_size(src_w_r);
  assign esrc[1] = eff_size(src_h_r);
  assign edst[0] = eff_size(dst_w_r);
  assign edst[1] = eff_size(dst_h_r);

  // Input handshake and frame writes.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_en       = in_acc && (in_ch.opcode == OP_WRITE)
                    && (CMP_W'(in_ch.pixel_x) < CMP_W'(MAX_SIDE))
                    && (CMP_W'(in_ch.pixel_y) < CMP_W'(MAX_SIDE));
  assign waddr = ADDR_W'(SIDE_W'(in_ch.pixel_y)) * SIDE_A
               + ADDR_W'(SIDE_W'(in_ch.pixel_x));

  // Source position numerator, made non-negative, and the fraction-scaled dividend.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      prod_nxt[a] = PRD_W'({coord_r[a], 1'b1}) * PRD_W'(esrc[a]);
      neg_nxt[a]  = (prod_r[a] < PRD_W'(edst[a]));
      dvd[a] = {(neg_nxt[a] ? NUM_W'(prod_r[a]) + NUM_W'(edst[a])
                            : NUM_W'(prod_r[a]) - NUM_W'(edst[a])),
                {FRAC_W{1'b0}}};
      dvs[a] = {edst[a], 1'b0};
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_div
    brr_div #(
      .DVD_W (DVD_W),
      .DVS_W (DEN_W)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (dvd[g]),
      .divisor  (dvs[g]),
      .busy     (div_busy[g]),
      .quotient (quo[g])
    );
  end

  // Neighbour indices clamped to the source edges; a negative position clamps to zero.
  always_comb begin
    logic [NUM_W-1:0] qi;
    logic [NUM_W-1:0] qi1;
    logic [NUM_W-1:0] lim;
    for (int a = 0; a < 2; a++) begin
      qi  = quo[a][DVD_W-1:FRAC_W];
      qi1 = qi + NUM_W'(1);
      lim = NUM_W'(esrc[a]) - NUM_W'(1);
      if (neg_r[a]) begin
        lo_nxt[a] = '0;
        hi_nxt[a] = '0;
      end else begin
        lo_nxt[a] = SIDE_W'((qi > lim) ? lim : qi);
        hi_nxt[a] = SIDE_W'((qi1 > lim) ? lim : qi1);
      end
    end
  end

  // Neighbour read address: bit 0 of the counter picks the column, bit 1 the row.
  assign ax    = fcnt_r[0] ? hi_r[0] : lo_r[0];
  assign ay    = fcnt_r[1] ? hi_r[1] : lo_r[1];
  assign raddr = ADDR_W'(ay) * SIDE_A + ADDR_W'(ax);
  assign fidx  = fcnt_r[NBR_W-1:0] - NBR_W'(1);

  brr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (in_ch.pixel_value),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  brr_blend u_blend (
    .clk    (clk),
    .ctl    (blend_ctl),
    .quad   (quad_r),
    .wx     (w_r[0]),
    .wy     (w_r[1]),
    .result (blend_res)
  );

  // Sequencer: next state and step controls.
  always_comb begin
    state_nxt = state_r;
    fcnt_nxt  = fcnt_r;
    div_start = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    blend_ctl = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.opcode == OP_READ)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!(|div_busy)) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        fcnt_nxt  = '0;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        rd_en    = (fcnt_r < FCNT_W'(NBR_N));
        fcnt_nxt = fcnt_r + FCNT_W'(1);
        if (fcnt_r == FCNT_W'(NBR_N)) begin
          state_nxt = ST_BLEND;
        end
      end
      ST_BLEND: begin
        blend_ctl.mix_horz = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        blend_ctl.mix_vert = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      coord_r[0] <= in_ch.pixel_x;
      coord_r[1] <= in_ch.pixel_y;
    end
    for (int a = 0; a < 2; a++) begin
      if (state_r == ST_MUL) begin
        prod_r[a] <= prod_nxt[a];
      end
      if (state_r == ST_NORM) begin
        neg_r[a] <= neg_nxt[a];
      end
      if (state_r == ST_CLAMP) begin
        lo_r[a] <= lo_nxt[a];
        hi_r[a] <= hi_nxt[a];
        w_r[a]  <= quo[a][FRAC_W-1:0];
      end
    end
    if ((state_r == ST_FETCH) && (fcnt_r != '0)) begin
      quad_r[fidx] <= rdata;
    end
    if (out_load) begin
      out_data_r <= blend_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sampled_value = out_data_r;

endmodule

>>> tb/tb_bilinear_rgba_resize_top.sv
// Self-checking testbench for the bilinear RGBA resampler, with its scoreboard class.
module tb_bilinear_rgba_resize_top import brr_pkg::*; ();

  // Frame addresses of the four neighbours, in the order p00, p01, p10, p11.
  typedef int corner_addr_t [NBR_N];

  localparam int UNITY     = 1 << FRAC_W;
  localparam int SETTLE_CY = 80;
  localparam int TOTAL_WDS = 1700;

  // Scoreboard: mirrors the size registers and the source frame, works out each
  // sample when a read word is accepted and checks results in order.
  class resample_scoreboard;
    logic [CFG_W-1:0] size_reg [4];
    bit [PIX_W-1:0]   frame [int];
    bit [PIX_W-1:0]   pending [$];
    int               errors;

    function new();
      foreach (size_reg[i]) size_reg[i] = 1;
      errors = 0;
    endfunction

    // A size of zero behaves as one and anything above the store side as the side.
    function int span(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
      return int'(v);
    endfunction

    function longint clip(longint v, int n);
      if (v < 0) return 0;
      if (v >= n) return n - 1;
      return v;
    endfunction

    // Half-pixel-centre mapping of one axis: floor quotient, truncated weight.
    function void map_axis(int d, int src, int dst, output int i0, output int i1,
                           output int w);
      longint num, den, q, r;
      num = longint'(2 * d + 1) * src - dst;
      den = 2 * dst;
      if (num >= 0) q = num / den;
      else q = -((-num + den - 1) / den);
      r  = num - q * den;
      w  = int'((r * UNITY) / den);
      i0 = int'(clip(q, src));
      i1 = int'(clip(q + 1, src));
    endfunction

    function void locate_quad(int x, int y, output corner_addr_t addr, output int wx,
                              output int wy);
      int x0, x1, y0, y1;
      map_axis(x, span(size_reg[CFG_SRC_W]), span(size_reg[CFG_DST_W]), x0, x1, wx);
      map_axis(y, span(size_reg[CFG_SRC_H]), span(size_reg[CFG_DST_H]), y0, y1, wy);
      addr[0] = y0 * MAX_SIDE_DEF + x0;
      addr[1] = y0 * MAX_SIDE_DEF + x1;
      addr[2] = y1 * MAX_SIDE_DEF + x0;
      addr[3] = y1 * MAX_SIDE_DEF + x1;
    endfunction

    // An accepted write word updates the frame; a read word queues its sample.
    function void note_word(op_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [PIX_W-1:0] v);
      corner_addr_t   addr;
      int             wx, wy, top, bot;
      int             p [NBR_N];
      bit [PIX_W-1:0] q [NBR_N];
      bit [PIX_W-1:0] sample;
      if (op == OP_WRITE) begin
        frame[int'(y) * MAX_SIDE_DEF + int'(x)] = v;
        return;
      end
      locate_quad(int'(x), int'(y), addr, wx, wy);
      foreach (addr[i]) q[i] = frame.exists(addr[i]) ? frame[addr[i]] : '0;
      sample = '0;
      for (int c = 0; c < CH_N; c++) begin
        foreach (p[i]) p[i] = int'(q[i][c*CH_W +: CH_W]);
        top = p[0] * (UNITY - wx) + p[1] * wx;
        bot = p[2] * (UNITY - wx) + p[3] * wx;
        sample[c*CH_W +: CH_W] = CH_W'((top * (UNITY - wy) + bot * wy) >> (2 * FRAC_W));
      end
      pending.push_back(sample);
    endfunction

    function void check_sample(logic [PIX_W-1:0] got);
      bit [PIX_W-1:0] want;
      if (pending.size() == 0) begin
        $error("sampled_value arrived with no sample outstanding: got %08h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("sampled_value mismatch: expected %08h, got %08h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  int   hold_left;
  int   words_sent;
  bit   burst;
  resample_scoreboard sb;

  brr_in_if  in_ch ();
  brr_out_if out_ch ();
  brr_cfg_if cfg_ch ();

  bilinear_rgba_resize_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // Result ready: random stalls, or a long hold-off counted down here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= out_idle_pct);
    end
  end

  // Every result word taken by the receiver is checked against the oldest sample.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_sample(out_ch.sampled_value);
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_side(int common_max);
    case ($urandom_range(9, 0))
      0: return '0;
      1: return CFG_W'($urandom_range(511, 257));
      2: return CFG_W'(MAX_SIDE_DEF);
      default: return CFG_W'($urandom_range(common_max, 1));
    endcase
  endfunction

  // Offers one input word after any idle cycles and returns once accepted.
  // Valid is left high so that a following word can go out on the next cycle.
  task automatic send_word(op_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [PIX_W-1:0] v);
    @(negedge clk);
    while (!burst && $urandom_range(99, 0) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.pixel_x     <= x;
    in_ch.pixel_y     <= y;
    in_ch.pixel_value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_word(op, x, y, v);
    words_sent++;
  endtask

  // A read only ever touches written pixels: missing neighbours are written first.
  task automatic request_sample(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    corner_addr_t addr;
    int           wx, wy;
    sb.locate_quad(int'(x), int'(y), addr, wx, wy);
    foreach (addr[i]) begin
      if (!sb.frame.exists(addr[i])) begin
        send_word(OP_WRITE, COORD_W'(addr[i] % MAX_SIDE_DEF),
                  COORD_W'(addr[i] / MAX_SIDE_DEF), rand_pixel());
      end
    end
    send_word(OP_READ, x, y, $urandom);
  endtask

  // Drops valid, waits for every outstanding sample, then lets the block go idle.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CY) @(posedge clk);
  endtask

  // Writes all four size registers back to back; only called while idle.
  task automatic program_sizes(logic [CFG_W-1:0] sw, logic [CFG_W-1:0] sh,
                               logic [CFG_W-1:0] tw, logic [CFG_W-1:0] th);
    cfg_idx_t         order [4];
    logic [CFG_W-1:0] vals [4];
    order = '{CFG_SRC_W, CFG_SRC_H, CFG_DST_W, CFG_DST_H};
    vals  = '{sw, sh, tw, th};
    foreach (order[i]) begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= order[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      sb.size_reg[order[i]] = vals[i];
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Timeout guard.
  initial begin
    #4000000;
    $display("tb_bilinear_rgba_resize_top NOT OK");
    $finish;
  end

  // Main stimulus: directed words, then phases of random traffic.
  initial begin
    logic [CFG_W-1:0]   sz [4];
    logic [COORD_W-1:0] x, y;
    int                 phase, sw_e, sh_e, tw_e, th_e;
    sb = new();
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_WRITE;
    in_ch.pixel_x     = '0;
    in_ch.pixel_y     = '0;
    in_ch.pixel_value = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_SRC_W;
    cfg_ch.data       = '0;
    in_idle_pct       = 0;
    out_idle_pct      = 0;
    hold_left         = 0;
    words_sent        = 0;
    burst             = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sizes at their reset value of one: every destination collapses onto pixel (0,0),
    // including coordinates far outside the target.
    send_word(OP_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_word(OP_WRITE, 8'd255, 8'd255, 32'h0000_0000);
    send_word(OP_WRITE, 8'd255, 8'd0, 32'h5A5A_A5A5);
    send_word(OP_READ, 8'd0, 8'd0, 32'h0000_0000);
    send_word(OP_READ, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_word(OP_WRITE, 8'd0, 8'd0, 32'h80FF_007F);
    send_word(OP_READ, 8'd128, 8'd127, 32'h1234_5678);

    // Two by two source, target width over range and target height zero.
    settle();
    program_sizes(9'd2, 9'd2, 9'd511, 9'd0);
    send_word(OP_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_word(OP_WRITE, 8'd1, 8'd0, 32'h0000_0000);
    send_word(OP_WRITE, 8'd0, 8'd1, 32'h00FF_00FF);
    send_word(OP_WRITE, 8'd1, 8'd1, 32'hFF00_FF00);
    send_word(OP_READ, 8'd0, 8'd0, 32'h0);
    send_word(OP_READ, 8'd127, 8'd0, 32'h0);
    send_word(OP_READ, 8'd128, 8'd0, 32'h0);
    send_word(OP_READ, 8'd255, 8'd0, 32'h0);
    send_word(OP_READ, 8'd200, 8'd255, 32'h0);

    // Random phases; idling pattern follows progress through the run.
    phase = 0;
    while (words_sent < TOTAL_WDS) begin
      if (words_sent < TOTAL_WDS / 3) begin
        in_idle_pct  = 31;
        out_idle_pct = 53;
      end else if (words_sent < 2 * TOTAL_WDS / 3) begin
        in_idle_pct  = 53;
        out_idle_pct = 31;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (phase)
        0: sz = '{9'd6, 9'd5, 9'd13, 9'd9};
        1: sz = '{9'd511, 9'd511, 9'd1, 9'd1};
        2: sz = '{9'd1, 9'd1, 9'd511, 9'd511};
        3: sz = '{9'd256, 9'd256, 9'd256, 9'd256};
        4: sz = '{9'd0, 9'd300, 9'd0, 9'd257};
        default: sz = '{pick_side(12), pick_side(12), pick_side(40), pick_side(40)};
      endcase
      settle();
      program_sizes(sz[0], sz[1], sz[2], sz[3]);
      sw_e = sb.span(sz[0]);
      sh_e = sb.span(sz[1]);
      tw_e = sb.span(sz[2]);
      th_e = sb.span(sz[3]);

      // Small sources are loaded whole before any sampling.
      if (sw_e * sh_e <= 144) begin
        for (int yy = 0; yy < sh_e; yy++) begin
          for (int xx = 0; xx < sw_e; xx++) begin
            send_word(OP_WRITE, COORD_W'(xx), COORD_W'(yy), rand_pixel());
          end
        end
      end

      // Receiver holds off while reads keep coming, so the block backs up.
      if (phase == 0) begin
        hold_left = 600;
        burst     = 1'b1;
        repeat (40) begin
          request_sample(COORD_W'($urandom_range(tw_e - 1, 0)),
                         COORD_W'($urandom_range(th_e - 1, 0)));
        end
        burst = 1'b0;
      end

      repeat (90) begin
        if (words_sent >= TOTAL_WDS) break;
        if ($urandom_range(99, 0) < 65) begin
          x = ($urandom_range(4, 0) == 0) ? COORD_W'($urandom) :
                                            COORD_W'($urandom_range(tw_e - 1, 0));
          y = ($urandom_range(4, 0) == 0) ? COORD_W'($urandom) :
                                            COORD_W'($urandom_range(th_e - 1, 0));
          request_sample(x, y);
        end else if ($urandom_range(1, 0) == 0) begin
          send_word(OP_WRITE, COORD_W'($urandom_range(sw_e - 1, 0)),
                    COORD_W'($urandom_range(sh_e - 1, 0)), rand_pixel());
        end else begin
          send_word(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom), rand_pixel());
        end
      end
      phase++;
    end

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_bilinear_rgba_resize_top OK");
    end else begin
      $display("tb_bilinear_rgba_resize_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
sv/brr_pkg.sv
sv/brr_ifs.sv
sv/brr_ram.sv
sv/brr_div.sv
sv/brr_blend.sv
sv/bilinear_rgba_resize_top.sv
tb/tb_bilinear_rgba_resize_top.sv
